// ----- src/tked_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder package
// Byte classes, token format and key codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package tked_pkg;

    localparam logic [7:0] CHAR_ESC      = 8'h1b;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHAR_UPPER_O  = 8'h4f;
    localparam logic [7:0] CHAR_TILDE    = 8'h7e;
    localparam logic [7:0] CHAR_UPPER_C  = 8'h43;
    localparam logic [7:0] CHAR_UPPER_D  = 8'h44;
    localparam logic [7:0] CHAR_UPPER_H  = 8'h48;
    localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHAR_LOWER_Q  = 8'h71;
    localparam logic [7:0] CHAR_UPPER_Q  = 8'h51;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam int unsigned ACC_W = 8;
    localparam logic [ACC_W-1:0] ACC_MAX = 8'd255;

    typedef enum logic [3:0] {
        CLS_OTHER    = 4'd0,
        CLS_ESC      = 4'd1,
        CLS_LBRACKET = 4'd2,
        CLS_UPPER_O  = 4'd3,
        CLS_TILDE    = 4'd4,
        CLS_C        = 4'd5,
        CLS_D        = 4'd6,
        CLS_H        = 4'd7,
        CLS_F        = 4'd8,
        CLS_QUIT     = 4'd9,
        CLS_DIGIT    = 4'd10,
        CLS_TIMEOUT  = 4'd11
    } t_byte_class;

    typedef struct packed {
        t_byte_class cls;
        logic [3:0]  digit;
    } t_token;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_QUIT  = 3'd1,
        KEY_RIGHT = 3'd2,
        KEY_LEFT  = 3'd3,
        KEY_HOME  = 3'd4,
        KEY_END   = 3'd5,
        KEY_PGUP  = 3'd6,
        KEY_PGDN  = 3'd7
    } t_key;

endpackage

// ----- src/tked_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder input channel
// Carries one received byte or one timeout tick per word.
// ----------------------------------------------------------------------------
interface tked_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] byte_value;

    modport source (output valid, output command, output byte_value, input ready);
    modport sink   (input valid, input command, input byte_value, output ready);
endinterface

// ----- src/tked_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder output channel
// Carries one key code per word.
// ----------------------------------------------------------------------------
interface tked_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// ----- src/tked_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder front end
// Accepts input words and classifies each into a compact token.
// ----------------------------------------------------------------------------
module tked_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_command,
    input  logic [7:0]      i_byte_value,
    output logic            o_tok_valid,
    input  logic            i_tok_ready,
    output tked_pkg::t_token o_tok
);

    logic             r_valid;
    tked_pkg::t_token r_tok;
    tked_pkg::t_token n_tok;
    logic             w_accept;

    always_comb begin
        n_tok.digit = i_byte_value[3:0];
        n_tok.cls   = tked_pkg::CLS_OTHER;
        if (i_command == tked_pkg::CMD_TIMEOUT) begin
            n_tok.cls = tked_pkg::CLS_TIMEOUT;
        end else if (i_byte_value >= tked_pkg::CHAR_ZERO &&
                     i_byte_value <= tked_pkg::CHAR_NINE) begin
            n_tok.cls = tked_pkg::CLS_DIGIT;
        end else begin
            unique case (i_byte_value)
                tked_pkg::CHAR_ESC:      n_tok.cls = tked_pkg::CLS_ESC;
                tked_pkg::CHAR_LBRACKET: n_tok.cls = tked_pkg::CLS_LBRACKET;
                tked_pkg::CHAR_UPPER_O:  n_tok.cls = tked_pkg::CLS_UPPER_O;
                tked_pkg::CHAR_TILDE:    n_tok.cls = tked_pkg::CLS_TILDE;
                tked_pkg::CHAR_UPPER_C:  n_tok.cls = tked_pkg::CLS_C;
                tked_pkg::CHAR_UPPER_D:  n_tok.cls = tked_pkg::CLS_D;
                tked_pkg::CHAR_UPPER_H:  n_tok.cls = tked_pkg::CLS_H;
                tked_pkg::CHAR_UPPER_F:  n_tok.cls = tked_pkg::CLS_F;
                tked_pkg::CHAR_LOWER_Q,
                tked_pkg::CHAR_UPPER_Q:  n_tok.cls = tked_pkg::CLS_QUIT;
                default:                 n_tok.cls = tked_pkg::CLS_OTHER;
            endcase
        end
    end

    assign o_ready     = !r_valid || i_tok_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_tok_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok <= n_tok;
        end
    end

endmodule

// ----- src/tked_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder token queue
// Two-entry first-in first-out buffer between front and back ends.
// ----------------------------------------------------------------------------
module tked_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  tked_pkg::t_token i_push_tok,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output tked_pkg::t_token o_pop_tok
);

    tked_pkg::t_token r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_tok    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

// ----- src/tked_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key decoder back end
// Runs the escape-sequence parser on tokens and registers the key code.
// ----------------------------------------------------------------------------
module tked_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    output logic             o_tok_ready,
    input  tked_pkg::t_token i_tok,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_key_code
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ESC     = 5'b00010,
        ST_CSI     = 5'b00100,
        ST_CSI_NUM = 5'b01000,
        ST_SS3     = 5'b10000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [tked_pkg::ACC_W-1:0]      r_acc;
    logic [tked_pkg::ACC_W-1:0]      n_acc;
    tked_pkg::t_key                  r_key;
    tked_pkg::t_key                  n_key;
    logic                            r_out_valid;
    logic                            w_take;
    logic [tked_pkg::ACC_W+3:0]      w_acc_next;
    tked_pkg::t_key                  w_idle_key;
    t_state                          w_idle_state;

    assign o_tok_ready = !r_out_valid || i_ready;
    assign w_take      = i_tok_valid && o_tok_ready;
    assign o_valid     = r_out_valid;
    assign o_key_code  = r_key;

    // acc * 10 + digit, as shifts and adds
    assign w_acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {{tked_pkg::ACC_W{1'b0}}, i_tok.digit};

    // Behaviour of a byte seen in idle; also used when a lone ESC is abandoned.
    always_comb begin
        w_idle_state = ST_IDLE;
        w_idle_key   = tked_pkg::KEY_NONE;
        unique case (i_tok.cls)
            tked_pkg::CLS_ESC:  w_idle_state = ST_ESC;
            tked_pkg::CLS_QUIT: w_idle_key   = tked_pkg::KEY_QUIT;
            default:            w_idle_key   = tked_pkg::KEY_NONE;
        endcase
    end

    always_comb begin
        n_state = ST_IDLE;
        n_acc   = '0;
        n_key   = tked_pkg::KEY_NONE;
        if (i_tok.cls == tked_pkg::CLS_TIMEOUT) begin
            if (r_state == ST_ESC) begin
                n_key = tked_pkg::KEY_QUIT;
            end
        end else begin
            unique case (r_state)
                ST_ESC: begin
                    if (i_tok.cls == tked_pkg::CLS_LBRACKET) begin
                        n_state = ST_CSI;
                    end else if (i_tok.cls == tked_pkg::CLS_UPPER_O) begin
                        n_state = ST_SS3;
                    end else begin
                        n_state = w_idle_state;
                        n_key   = w_idle_key;
                    end
                end
                ST_CSI: begin
                    unique case (i_tok.cls)
                        tked_pkg::CLS_DIGIT: begin
                            n_state = ST_CSI_NUM;
                            n_acc   = {{(tked_pkg::ACC_W-4){1'b0}}, i_tok.digit};
                        end
                        tked_pkg::CLS_C: n_key = tked_pkg::KEY_RIGHT;
                        tked_pkg::CLS_D: n_key = tked_pkg::KEY_LEFT;
                        tked_pkg::CLS_H: n_key = tked_pkg::KEY_HOME;
                        tked_pkg::CLS_F: n_key = tked_pkg::KEY_END;
                        default:         n_key = tked_pkg::KEY_NONE;
                    endcase
                end
                ST_CSI_NUM: begin
                    if (i_tok.cls == tked_pkg::CLS_DIGIT) begin
                        n_state = ST_CSI_NUM;
                        if (w_acc_next[tked_pkg::ACC_W+3:tked_pkg::ACC_W] != 4'd0) begin
                            n_acc = tked_pkg::ACC_MAX;
                        end else begin
                            n_acc = w_acc_next[tked_pkg::ACC_W-1:0];
                        end
                    end else if (i_tok.cls == tked_pkg::CLS_TILDE) begin
                        unique case (r_acc) inside
                            8'd1, 8'd7: n_key = tked_pkg::KEY_HOME;
                            8'd4, 8'd8: n_key = tked_pkg::KEY_END;
                            8'd5:       n_key = tked_pkg::KEY_PGUP;
                            8'd6:       n_key = tked_pkg::KEY_PGDN;
                            default:    n_key = tked_pkg::KEY_NONE;
                        endcase
                    end
                end
                ST_SS3: begin
                    unique case (i_tok.cls)
                        tked_pkg::CLS_H: n_key = tked_pkg::KEY_HOME;
                        tked_pkg::CLS_F: n_key = tked_pkg::KEY_END;
                        default:         n_key = tked_pkg::KEY_NONE;
                    endcase
                end
                default: begin
                    n_state = w_idle_state;
                    n_key   = w_idle_key;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_state     <= n_state;
                r_acc       <= n_acc;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key <= n_key;
        end
    end

endmodule

// ----- src/terminal_key_escape_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key escape decoder
// Turns keyboard bytes and timeout ticks into one key code per input word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  i_item    in         command (byte or timeout), byte_value
//  o_key     out        key_code
//
//  One word is accepted per cycle when the output is drained; each input word
//  gives exactly one output word, through the front register, the queue and
//  the output register.
//  Reset (i_rst_n low, synchronous) returns the parser to idle and empties
//  every stage. A stall on o_key fills the two-entry queue and the front
//  register before i_item.ready falls.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tked_in_if.sink    i_item,
    tked_out_if.source o_key
);

    logic             w_front_valid;
    logic             w_front_ready;
    tked_pkg::t_token w_front_tok;
    logic             w_back_valid;
    logic             w_back_ready;
    tked_pkg::t_token w_back_tok;

    tked_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_item.valid),
        .o_ready      (i_item.ready),
        .i_command    (i_item.command),
        .i_byte_value (i_item.byte_value),
        .o_tok_valid  (w_front_valid),
        .i_tok_ready  (w_front_ready),
        .o_tok        (w_front_tok)
    );

    tked_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_tok   (w_front_tok),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_tok    (w_back_tok)
    );

    tked_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_back_valid),
        .o_tok_ready (w_back_ready),
        .i_tok       (w_back_tok),
        .o_valid     (o_key.valid),
        .i_ready     (o_key.ready),
        .o_key_code  (o_key.key_code)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal key escape decoder testbench
// Sends keyboard bytes and timeout ticks to the decoder, predicts each key
// code from its own copy of the parser and checks every output word against
// the oldest prediction, under random idling, a long receiver hold-off and
// sender pauses.
// ----------------------------------------------------------------------------
module testbench;
    import tked_pkg::*;

    typedef enum logic [2:0] {
        PS_IDLE    = 3'd0,
        PS_ESC     = 3'd1,
        PS_CSI     = 3'd2,
        PS_CSI_NUM = 3'd3,
        PS_SS3     = 3'd4
    } parser_state_t;

    logic i_clk;
    logic i_rst_n;

    tked_in_if  item_if ();
    tked_out_if key_if ();

    terminal_key_escape_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_key   (key_if)
    );

    parser_state_t parse_state;
    logic [7:0]    number_acc;
    t_key          expected_keys[$];

    bit sender_gaps_on  = 1'b1;
    bit sink_stalls_on  = 1'b1;
    int holdoff_cycles  = 0;
    int words_sent      = 0;
    int timeouts_sent   = 0;
    int keys_checked    = 0;
    int errors          = 0;
    int key_count [8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Key decoding of a byte seen in idle; may move the parser on to ESC.
    function automatic t_key idle_key(input logic [7:0] b);
        if (b == CHAR_ESC) begin
            parse_state = PS_ESC;
            return KEY_NONE;
        end
        if (b == CHAR_LOWER_Q || b == CHAR_UPPER_Q) return KEY_QUIT;
        return KEY_NONE;
    endfunction

    function automatic t_key decode_key(input logic cmd, input logic [7:0] b);
        t_key        k;
        int unsigned v;
        bit          is_digit;
        k        = KEY_NONE;
        is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
        if (cmd == CMD_TIMEOUT) begin
            if (parse_state == PS_ESC) k = KEY_QUIT;
            parse_state = PS_IDLE;
            number_acc  = '0;
            return k;
        end
        case (parse_state)
            PS_ESC: begin
                if (b == CHAR_LBRACKET) begin
                    parse_state = PS_CSI;
                end else if (b == CHAR_UPPER_O) begin
                    parse_state = PS_SS3;
                end else begin
                    // A lone ESC is dropped and the byte is taken afresh.
                    parse_state = PS_IDLE;
                    number_acc  = '0;
                    k = idle_key(b);
                end
            end
            PS_CSI: begin
                if (is_digit) begin
                    number_acc  = b - CHAR_ZERO;
                    parse_state = PS_CSI_NUM;
                end else begin
                    case (b)
                        CHAR_UPPER_C: k = KEY_RIGHT;
                        CHAR_UPPER_D: k = KEY_LEFT;
                        CHAR_UPPER_H: k = KEY_HOME;
                        CHAR_UPPER_F: k = KEY_END;
                        default:      k = KEY_NONE;
                    endcase
                    parse_state = PS_IDLE;
                    number_acc  = '0;
                end
            end
            PS_CSI_NUM: begin
                if (is_digit) begin
                    v = 32'(number_acc) * 32'd10 + 32'(8'(b - CHAR_ZERO));
                    number_acc = (v > 32'(ACC_MAX)) ? ACC_MAX : v[7:0];
                end else begin
                    if (b == CHAR_TILDE) begin
                        case (number_acc)
                            8'd1, 8'd7: k = KEY_HOME;
                            8'd4, 8'd8: k = KEY_END;
                            8'd5:       k = KEY_PGUP;
                            8'd6:       k = KEY_PGDN;
                            default:    k = KEY_NONE;
                        endcase
                    end
                    parse_state = PS_IDLE;
                    number_acc  = '0;
                end
            end
            PS_SS3: begin
                if (b == CHAR_UPPER_H) k = KEY_HOME;
                else if (b == CHAR_UPPER_F) k = KEY_END;
                parse_state = PS_IDLE;
                number_acc  = '0;
            end
            default: k = idle_key(b);
        endcase
        return k;
    endfunction

    // Offers one word and holds it until the decoder takes it. Valid is left
    // high so that back-to-back words are offered without a gap.
    task automatic send_word(input logic cmd, input logic [7:0] b);
        if (sender_gaps_on) begin
            while ($urandom_range(99) < 31) begin
                item_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        item_if.valid      <= 1'b1;
        item_if.command    <= cmd;
        item_if.byte_value <= b;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        expected_keys.push_back(decode_key(cmd, b));
        words_sent++;
        if (cmd == CMD_TIMEOUT) timeouts_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(CMD_BYTE, b);
    endtask

    task automatic send_timeout();
        send_word(CMD_TIMEOUT, 8'($urandom_range(255)));
    endtask

    task automatic wait_all_keys();
        item_if.valid <= 1'b0;
        while (expected_keys.size() != 0) @(posedge i_clk);
    endtask

    // One escape sequence or stray byte; mostly well formed, sometimes cut
    // short by a timeout or ended by an arbitrary byte.
    task automatic send_random_sequence();
        int         pick;
        int         n_digits;
        logic [7:0] tail;
        pick = $urandom_range(99);
        if (pick < 65) begin
            send_byte(CHAR_ESC);
            if ($urandom_range(99) < 5) begin
                send_timeout();
                return;
            end
        end
        if (pick < 30) begin
            send_byte(CHAR_LBRACKET);
            case ($urandom_range(4))
                0: tail = CHAR_UPPER_C;
                1: tail = CHAR_UPPER_D;
                2: tail = CHAR_UPPER_H;
                3: tail = CHAR_UPPER_F;
                default: tail = 8'($urandom_range(255));
            endcase
            if ($urandom_range(99) < 5) send_timeout();
            else send_byte(tail);
        end else if (pick < 55) begin
            send_byte(CHAR_LBRACKET);
            n_digits = ($urandom_range(99) < 65) ? 1 : $urandom_range(2, 4);
            for (int i = 0; i < n_digits; i++) begin
                if (n_digits == 1 && $urandom_range(99) < 75) begin
                    case ($urandom_range(5))
                        0: tail = CHAR_ZERO + 8'd1;
                        1: tail = CHAR_ZERO + 8'd4;
                        2: tail = CHAR_ZERO + 8'd5;
                        3: tail = CHAR_ZERO + 8'd6;
                        4: tail = CHAR_ZERO + 8'd7;
                        default: tail = CHAR_ZERO + 8'd8;
                    endcase
                end else begin
                    tail = CHAR_ZERO + 8'($urandom_range(9));
                end
                send_byte(tail);
            end
            if ($urandom_range(99) < 5) send_timeout();
            else if ($urandom_range(99) < 85) send_byte(CHAR_TILDE);
            else send_byte(8'($urandom_range(255)));
        end else if (pick < 65) begin
            send_byte(CHAR_UPPER_O);
            case ($urandom_range(2))
                0: send_byte(CHAR_UPPER_H);
                1: send_byte(CHAR_UPPER_F);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end else if (pick < 75) begin
            // No ESC before it: send a quit key, a lone ESC or noise.
            case ($urandom_range(3))
                0: send_byte(CHAR_LOWER_Q);
                1: send_byte(CHAR_ESC);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end else if (pick < 85) begin
            send_byte(($urandom_range(1) != 0) ? CHAR_LOWER_Q : CHAR_UPPER_Q);
        end else if (pick < 92) begin
            send_timeout();
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CHAR_UPPER_Q);
        send_timeout();
        // Timeout after a bare ESC is a quit.
        send_byte(CHAR_ESC);
        send_timeout();
        // A lone ESC followed by 'q' still quits.
        send_byte(CHAR_ESC);
        send_byte(CHAR_LOWER_Q);
        send_byte(CHAR_ESC);
        send_byte(CHAR_LBRACKET);
        send_byte(CHAR_UPPER_D);
        send_byte(CHAR_ESC);
        send_byte(CHAR_UPPER_O);
        send_byte(CHAR_UPPER_H);
        // Long parameter saturates and maps to nothing.
        send_byte(CHAR_ESC);
        send_byte(CHAR_LBRACKET);
        for (int i = 0; i < 3; i++) send_byte(CHAR_NINE);
        send_byte(CHAR_TILDE);
        send_byte(CHAR_ESC);
        send_byte(CHAR_LBRACKET);
        send_byte(CHAR_ZERO + 8'd6);
        send_byte(CHAR_TILDE);
        wait_all_keys();
    endtask

    task automatic test_random_traffic(input int target);
        while (words_sent < target) send_random_sequence();
        wait_all_keys();
    endtask

    task automatic test_no_idling(input int n_words);
        int stop_at;
        stop_at        = words_sent + n_words;
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        while (words_sent < stop_at) send_random_sequence();
        wait_all_keys();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // The receiver stops for a long while and the sender keeps offering,
    // so the decoder fills up and has to stall its input.
    task automatic test_receiver_holdoff(input int rounds);
        int stop_at;
        sender_gaps_on = 1'b0;
        for (int r = 0; r < rounds; r++) begin
            holdoff_cycles = 80;
            stop_at = words_sent + 30;
            while (words_sent < stop_at) send_random_sequence();
            wait_all_keys();
        end
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            send_random_sequence();
            wait_all_keys();
        end
    endtask

    // Receiver side: random stalls, plus the long hold-off on request.
    initial begin
        key_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_cycles > 0) begin
                holdoff_cycles--;
                key_if.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(99) < 31) begin
                key_if.ready <= 1'b0;
            end else begin
                key_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_key want;
        if (i_rst_n === 1'b1 && key_if.valid === 1'b1 && key_if.ready === 1'b1) begin
            if (expected_keys.size() == 0) begin
                $error("key_code: word with nothing outstanding, expected none, actual %0d",
                       key_if.key_code);
                errors++;
            end else begin
                want = expected_keys.pop_front();
                keys_checked++;
                key_count[want]++;
                if (key_if.key_code !== want) begin
                    $error("key_code mismatch: expected %0d (%s), actual %0d",
                           want, want.name(), key_if.key_code);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.command    = CMD_BYTE;
        item_if.byte_value = 8'h00;
        parse_state        = PS_IDLE;
        number_acc         = '0;
        foreach (key_count[k]) key_count[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(450);
        test_no_idling(200);
        test_receiver_holdoff(3);
        test_sender_pause(25);
        test_random_traffic(1150);

        wait_all_keys();
        // Wait on so that a stray word would still be seen.
        repeat (10) @(posedge i_clk);
        $display("Sent %0d words (%0d timeout ticks), checked %0d key codes, %0d errors.",
                 words_sent, timeouts_sent, keys_checked, errors);
        $display("Keys: none %0d quit %0d right %0d left %0d home %0d end %0d pgup %0d pgdn %0d",
                 key_count[0], key_count[1], key_count[2], key_count[3],
                 key_count[4], key_count[5], key_count[6], key_count[7]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tked_pkg.sv
src/tked_in_if.sv
src/tked_out_if.sv
src/tked_front.sv
src/tked_queue.sv
src/tked_back.sv
src/terminal_key_escape_decoder_core.sv
verif/testbench.sv
